@@ design/afl_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package afl_pkg;

  localparam int MAX_FRAMES_DEFAULT = 256;
  localparam int TIME_W             = 32;
  localparam int INDEX_W            = 9;
  localparam int MODE_W             = 2;
  localparam int STATUS_W           = 2;

  localparam logic [MODE_W-1:0] MODE_APPEND = 2'd0;
  localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd3;

  localparam logic [INDEX_W-1:0] INDEX_NONE = '1;
  localparam logic [TIME_W-1:0]  TOTAL_MAX  = '1;

  // Which table entry the datapath reads in the current cycle.
  typedef enum logic [2:0] {
    RD_LAST,
    RD_G,
    RD_G_DEC,
    RD_G_INC,
    RD_G_INC2
  } rd_sel_t;

  // Where the frame index of a result comes from.
  typedef enum logic [2:0] {
    RES_NONE,
    RES_COUNT,
    RES_LAST,
    RES_G,
    RES_ZERO
  } res_sel_t;

  typedef struct packed {
    logic                append;
    logic                clear;
    rd_sel_t             rd_sel;
    logic                mul;
    logic                div_init;
    logic                div_step;
    logic                g_clamp;
    logic                g_dec;
    logic                g_inc;
    logic                res_set;
    res_sel_t            res_sel;
    logic [STATUS_W-1:0] res_status;
    logic                push;
  } afl_cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              count_zero;
    logic              full;
    logic              sum_carry;
    logic              t_ge_rd;
    logic              rd_gt_t;
    logic              total_zero;
    logic              div_last;
    logic              g_zero;
    logic              g1_lt_n;
    logic              g2_lt_n;
    logic              out_free;
  } afl_status_t;

endpackage

`default_nettype wire

@@ design/afl_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface afl_req_if;
  logic                             valid;
  logic                             ready;
  logic [afl_pkg::MODE_W-1:0]       mode;
  logic [afl_pkg::TIME_W-1:0]       duration;
  logic [afl_pkg::TIME_W-1:0]       query_time;

  modport source (output valid, mode, duration, query_time, input ready);
  modport sink   (input valid, mode, duration, query_time, output ready);
endinterface

interface afl_rsp_if;
  logic                             valid;
  logic                             ready;
  logic signed [afl_pkg::INDEX_W-1:0] frame_index;
  logic [afl_pkg::TIME_W-1:0]       total_length;
  logic [afl_pkg::STATUS_W-1:0]     status;

  modport source (output valid, frame_index, total_length, status, input ready);
  modport sink   (input valid, frame_index, total_length, status, output ready);
endinterface

`default_nettype wire

@@ design/afl_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module afl_datapath #(
  parameter int MAX_FRAMES = afl_pkg::MAX_FRAMES_DEFAULT
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               accept,
  input  wire logic [afl_pkg::MODE_W-1:0]         in_mode,
  input  wire logic [afl_pkg::TIME_W-1:0]         in_duration,
  input  wire logic [afl_pkg::TIME_W-1:0]         in_query_time,
  input  wire afl_pkg::afl_cmd_t                  cmd,
  output afl_pkg::afl_status_t                    stat,
  input  wire logic                               out_ready,
  output logic                                    out_valid,
  output logic signed [afl_pkg::INDEX_W-1:0]      out_frame_index,
  output logic [afl_pkg::TIME_W-1:0]              out_total_length,
  output logic [afl_pkg::STATUS_W-1:0]            out_status
);

  localparam int TW  = afl_pkg::TIME_W;
  localparam int IW  = $clog2(MAX_FRAMES);
  localparam int CW  = $clog2(MAX_FRAMES + 1);
  localparam int PW  = TW + CW;
  localparam int DCW = $clog2(CW + 1);

  localparam logic [CW-1:0]  ONE      = CW'(1);
  localparam logic [CW-1:0]  TWO      = CW'(2);
  localparam logic [CW-1:0]  COUNT_MAX = CW'(MAX_FRAMES);
  localparam logic [CW:0]    ONE_W    = (CW + 1)'(1);
  localparam logic [CW:0]    TWO_W    = (CW + 1)'(2);
  localparam logic [DCW-1:0] DIV_STEPS = DCW'(CW);
  localparam logic [DCW-1:0] DIV_ONE  = DCW'(1);

  logic [afl_pkg::MODE_W-1:0]   mode;
  logic [TW-1:0]                duration;
  logic [TW-1:0]                query_time;
  logic [CW-1:0]                frame_total;
  logic [TW-1:0]                running_total;
  logic [TW-1:0]                start_table [MAX_FRAMES];
  logic [TW-1:0]                rd_data;
  logic [PW-1:0]                product;
  logic [TW-1:0]                rem;
  logic [CW-1:0]                quo;
  logic [DCW-1:0]               div_count;
  logic [CW-1:0]                g;
  logic [afl_pkg::INDEX_W-1:0]  res_idx;
  logic [afl_pkg::STATUS_W-1:0] res_status;

  logic [CW-1:0] rd_index;
  logic [TW:0]   sum;
  logic [TW:0]   rem_shift;
  logic          rem_ge;
  logic [CW-1:0] last_index;
  logic [afl_pkg::INDEX_W-1:0] idx_value;

  assign last_index = frame_total - ONE;
  assign sum        = {1'b0, running_total} + {1'b0, duration};
  assign rem_shift  = {rem, quo[CW-1]};
  assign rem_ge     = rem_shift >= {1'b0, running_total};

  always_comb begin
    case (cmd.rd_sel)
      afl_pkg::RD_LAST:   rd_index = last_index;
      afl_pkg::RD_G:      rd_index = g;
      afl_pkg::RD_G_DEC:  rd_index = g - ONE;
      afl_pkg::RD_G_INC:  rd_index = g + ONE;
      afl_pkg::RD_G_INC2: rd_index = g + TWO;
      default:            rd_index = g;
    endcase
  end

  always_comb begin
    case (cmd.res_sel)
      afl_pkg::RES_NONE:  idx_value = afl_pkg::INDEX_NONE;
      afl_pkg::RES_COUNT: idx_value = afl_pkg::INDEX_W'(frame_total);
      afl_pkg::RES_LAST:  idx_value = afl_pkg::INDEX_W'(last_index);
      afl_pkg::RES_G:     idx_value = afl_pkg::INDEX_W'(g);
      afl_pkg::RES_ZERO:  idx_value = '0;
      default:            idx_value = afl_pkg::INDEX_NONE;
    endcase
  end

  always_comb begin
    stat.mode       = mode;
    stat.count_zero = frame_total == '0;
    stat.full       = frame_total == COUNT_MAX;
    stat.sum_carry  = sum[TW];
    stat.t_ge_rd    = query_time >= rd_data;
    stat.rd_gt_t    = rd_data > query_time;
    stat.total_zero = running_total == '0;
    stat.div_last   = div_count == DIV_ONE;
    stat.g_zero     = g == '0;
    stat.g1_lt_n    = ({1'b0, g} + ONE_W) < {1'b0, frame_total};
    stat.g2_lt_n    = ({1'b0, g} + TWO_W) < {1'b0, frame_total};
    stat.out_free   = !out_valid || out_ready;
  end

  // Table memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.append) begin
      start_table[frame_total[IW-1:0]] <= running_total;
    end
    rd_data <= start_table[rd_index[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_total   <= '0;
      running_total <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cmd.append) begin
        frame_total   <= frame_total + ONE;
        running_total <= sum[TW] ? afl_pkg::TOTAL_MAX : sum[TW-1:0];
      end else if (cmd.clear) begin
        frame_total   <= '0;
        running_total <= '0;
      end
      if (cmd.push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode       <= in_mode;
      duration   <= in_duration;
      query_time <= in_query_time;
    end
    if (cmd.mul) begin
      product <= PW'(query_time) * PW'(frame_total);
    end
    // Restoring division of the product by the total, one quotient bit a cycle.
    // The quotient is below the frame count, so only CW bits are developed.
    if (cmd.div_init) begin
      rem       <= product[PW-1:CW];
      quo       <= product[CW-1:0];
      div_count <= DIV_STEPS;
    end else if (cmd.div_step) begin
      rem       <= rem_ge ? TW'(rem_shift - {1'b0, running_total}) : rem_shift[TW-1:0];
      quo       <= {quo[CW-2:0], rem_ge};
      div_count <= div_count - DIV_ONE;
    end
    if (cmd.g_clamp) begin
      g <= (quo >= frame_total) ? last_index : quo;
    end else if (cmd.g_dec) begin
      g <= g - ONE;
    end else if (cmd.g_inc) begin
      g <= g + ONE;
    end
    if (cmd.res_set) begin
      res_idx    <= idx_value;
      res_status <= cmd.res_status;
    end
    if (cmd.push) begin
      out_frame_index  <= res_idx;
      out_total_length <= running_total;
      out_status       <= res_status;
    end
  end

endmodule

`default_nettype wire

@@ design/afl_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module afl_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 accept,
  input  wire afl_pkg::afl_status_t stat,
  output logic                      in_ready,
  output afl_pkg::afl_cmd_t         cmd
);

  typedef enum logic [3:0] {
    IDLE,
    DISPATCH,
    Q_LAST,
    Q_DIVINIT,
    Q_DIV,
    Q_CLAMP,
    Q_RDG,
    Q_CMPG,
    Q_DN,
    Q_UP,
    FIN,
    PUSH
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == IDLE) && !rst;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      IDLE: begin
        if (accept) begin
          state_next = DISPATCH;
        end
      end
      DISPATCH: begin
        cmd.res_set = 1'b1;
        state_next  = PUSH;
        if (stat.mode == afl_pkg::MODE_APPEND) begin
          if (stat.full) begin
            cmd.res_sel    = afl_pkg::RES_NONE;
            cmd.res_status = afl_pkg::STATUS_FULL;
          end else begin
            cmd.append     = 1'b1;
            cmd.res_sel    = afl_pkg::RES_COUNT;
            cmd.res_status = stat.sum_carry ? afl_pkg::STATUS_OVERFLOW : afl_pkg::STATUS_OK;
          end
        end else if (stat.mode == afl_pkg::MODE_QUERY) begin
          if (stat.count_zero) begin
            cmd.res_sel    = afl_pkg::RES_NONE;
            cmd.res_status = afl_pkg::STATUS_EMPTY;
          end else begin
            cmd.res_set = 1'b0;
            cmd.rd_sel  = afl_pkg::RD_LAST;
            state_next  = Q_LAST;
          end
        end else if (stat.mode == afl_pkg::MODE_CLEAR) begin
          cmd.clear      = 1'b1;
          cmd.res_sel    = afl_pkg::RES_NONE;
          cmd.res_status = afl_pkg::STATUS_OK;
        end else begin
          cmd.res_sel    = afl_pkg::RES_NONE;
          cmd.res_status = afl_pkg::STATUS_OK;
        end
      end
      Q_LAST: begin
        if (stat.t_ge_rd) begin
          cmd.res_set    = 1'b1;
          cmd.res_sel    = afl_pkg::RES_LAST;
          cmd.res_status = afl_pkg::STATUS_OK;
          state_next     = PUSH;
        end else if (stat.total_zero) begin
          cmd.res_set    = 1'b1;
          cmd.res_sel    = afl_pkg::RES_ZERO;
          cmd.res_status = afl_pkg::STATUS_OK;
          state_next     = PUSH;
        end else begin
          cmd.mul    = 1'b1;
          state_next = Q_DIVINIT;
        end
      end
      Q_DIVINIT: begin
        cmd.div_init = 1'b1;
        state_next   = Q_DIV;
      end
      Q_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = Q_CLAMP;
        end
      end
      Q_CLAMP: begin
        cmd.g_clamp = 1'b1;
        state_next  = Q_RDG;
      end
      Q_RDG: begin
        cmd.rd_sel = afl_pkg::RD_G;
        state_next = Q_CMPG;
      end
      Q_CMPG: begin
        // The guess entry is in the read register: choose the walk direction.
        if (stat.rd_gt_t) begin
          if (stat.g_zero) begin
            state_next = FIN;
          end else begin
            cmd.g_dec  = 1'b1;
            cmd.rd_sel = afl_pkg::RD_G_DEC;
            state_next = Q_DN;
          end
        end else if (stat.g1_lt_n) begin
          cmd.rd_sel = afl_pkg::RD_G_INC;
          state_next = Q_UP;
        end else begin
          state_next = FIN;
        end
      end
      Q_DN: begin
        if (stat.rd_gt_t && !stat.g_zero) begin
          cmd.g_dec  = 1'b1;
          cmd.rd_sel = afl_pkg::RD_G_DEC;
        end else begin
          state_next = FIN;
        end
      end
      Q_UP: begin
        // The read register holds the entry just above the current index.
        if (!stat.rd_gt_t) begin
          cmd.g_inc = 1'b1;
          if (stat.g2_lt_n) begin
            cmd.rd_sel = afl_pkg::RD_G_INC2;
          end else begin
            state_next = FIN;
          end
        end else begin
          state_next = FIN;
        end
      end
      FIN: begin
        cmd.res_set    = 1'b1;
        cmd.res_sel    = afl_pkg::RES_G;
        cmd.res_status = afl_pkg::STATUS_OK;
        state_next     = PUSH;
      end
      PUSH: begin
        if (stat.out_free) begin
          cmd.push   = 1'b1;
          state_next = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

@@ design/animation_frame_lookup.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Frame lookup over a table of frame start times.
// The request channel carries one beat per item: mode 0 appends a frame of the
// given duration, mode 1 asks which frame covers query_time, mode 2 clears the
// table. Each request beat yields exactly one response beat with frame_index,
// the running total length and a status code.
// Items are handled one at a time; ready is high only while the block is idle.
// Append, clear and the unused mode, and a query on an empty table, go from
// dispatch straight to the push step. Any other query reads the last start
// time first and, if it hits the last frame or the total is zero, sets its
// result at once; otherwise it multiplies, divides, clamps the guess, reads
// the guess entry and walks the table before the result is set. The
// guess comes from a multiply and a restoring divider that develops one
// quotient bit a cycle; the walk reads one table entry a cycle.
// The response sits in an output register, so the request side is free again
// as soon as the beat is loaded; if the receiver stalls, a finished item waits
// in its last step until the register empties. Reset empties the table, zeroes
// the total and drops any pending response beat; no clearing pass is needed.

module animation_frame_lookup #(
  parameter int MAX_FRAMES = afl_pkg::MAX_FRAMES_DEFAULT
) (
  input wire logic   clk,
  input wire logic   rst,
  afl_req_if.sink    request,
  afl_rsp_if.source  response
);

  logic                 accept;
  logic                 in_ready;
  afl_pkg::afl_cmd_t    cmd;
  afl_pkg::afl_status_t stat;

  assign request.ready = in_ready;
  assign accept        = request.valid && in_ready;

  afl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .stat     (stat),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  afl_datapath #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .accept           (accept),
    .in_mode          (request.mode),
    .in_duration      (request.duration),
    .in_query_time    (request.query_time),
    .cmd              (cmd),
    .stat             (stat),
    .out_ready        (response.ready),
    .out_valid        (response.valid),
    .out_frame_index  (response.frame_index),
    .out_total_length (response.total_length),
    .out_status       (response.status)
  );

endmodule

`default_nettype wire

@@ design/afl_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module afl_checker (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               req_valid,
  input wire logic                               req_ready,
  input wire logic                               rsp_valid,
  input wire logic                               rsp_ready,
  input wire logic signed [afl_pkg::INDEX_W-1:0] rsp_frame_index,
  input wire logic [afl_pkg::TIME_W-1:0]         rsp_total_length,
  input wire logic [afl_pkg::STATUS_W-1:0]       rsp_status
);

  // A reset leaves no response beat pending.
  assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

  // Only one item is in flight: the request side closes after each beat.
  assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request accepted while an item is in flight");

  // Empty and full results never name a frame.
  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp_status == afl_pkg::STATUS_EMPTY ||
                   rsp_status == afl_pkg::STATUS_FULL))
    |-> rsp_frame_index == afl_pkg::INDEX_NONE)
    else $error("empty or full result carries a frame index");

  // An overflow result always shows the saturated total.
  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_status == afl_pkg::STATUS_OVERFLOW)
    |-> rsp_total_length == afl_pkg::TOTAL_MAX)
    else $error("overflow result without saturated total");

  // A stalled response beat holds.
  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_frame_index) &&
      $stable(rsp_total_length) && $stable(rsp_status)))
    else $error("stalled response beat changed");

endmodule

bind animation_frame_lookup afl_checker u_afl_checker (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (request.valid),
  .req_ready        (request.ready),
  .rsp_valid        (response.valid),
  .rsp_ready        (response.ready),
  .rsp_frame_index  (response.frame_index),
  .rsp_total_length (response.total_length),
  .rsp_status       (response.status)
);

`default_nettype wire

@@ test/animation_frame_lookup_tb.sv @@
`timescale 1ns / 1ps

module animation_frame_lookup_tb;

  localparam int TIME_W       = afl_pkg::TIME_W;
  localparam int MODE_W       = afl_pkg::MODE_W;
  localparam int INDEX_W      = afl_pkg::INDEX_W;
  localparam int STATUS_W     = afl_pkg::STATUS_W;
  localparam int MAX_FRAMES   = afl_pkg::MAX_FRAMES_DEFAULT;
  localparam int RANDOM_ITEMS = 1000;
  localparam int CYCLE_LIMIT  = 2000000;
  localparam int DRAIN_CYCLES = 300;
  localparam int HOLD_CYCLES  = 300;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [TIME_W-1:0] duration;
    logic [TIME_W-1:0] query_time;
  } frame_request_t;

  typedef struct packed {
    logic signed [INDEX_W-1:0] frame_index;
    logic [TIME_W-1:0]         total_length;
    logic [STATUS_W-1:0]       status;
  } frame_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  afl_req_if req_ch ();
  afl_rsp_if rsp_ch ();

  animation_frame_lookup u_top (
    .clk      (clk),
    .rst      (rst),
    .request  (req_ch),
    .response (rsp_ch)
  );

  always #6 clk = ~clk;

  frame_request_t item_backlog[$];
  frame_result_t  awaited_results[$];
  frame_request_t offered;

  int unsigned cycle_count    = 0;
  int unsigned sent_count     = 0;
  int unsigned got_count      = 0;
  int unsigned mismatch_count = 0;
  int unsigned planned_count  = 0;
  int unsigned hold_left      = 0;
  logic        hold_done      = 1'b0;

  // Timeline as the block should hold it, updated as each request beat is taken.
  logic [TIME_W-1:0] frame_start [MAX_FRAMES];
  int unsigned       frame_count = 0;
  logic [TIME_W-1:0] total_len   = '0;

  // Coarse copy of the timeline kept while the stimulus is planned, so that
  // query times can be aimed at frame boundaries.
  logic [TIME_W-1:0] plan_starts[$];
  logic [TIME_W-1:0] plan_total = '0;

  wire calm     = (sent_count >= 300) && (sent_count < 500);
  wire pause_ok = !calm && (hold_left == 0);

  function automatic int find_frame(input logic [TIME_W-1:0] t);
    int unsigned n;
    int unsigned g;
    logic [63:0] guess;
    n = frame_count;
    if (t >= frame_start[n - 1]) return n - 1;
    if (total_len == '0) return 0;
    guess = (64'(t) * 64'(n)) / 64'(total_len);
    g = (guess >= 64'(n)) ? n - 1 : guess[31:0];
    if (frame_start[g] > t) begin
      while (g > 0 && frame_start[g] > t) g--;
    end else begin
      while (g + 1 < n && frame_start[g + 1] <= t) g++;
    end
    return g;
  endfunction

  function automatic frame_result_t advance_timeline(input frame_request_t r);
    frame_result_t o;
    logic [TIME_W:0] sum;
    o.frame_index  = afl_pkg::INDEX_NONE;
    o.total_length = total_len;
    o.status       = afl_pkg::STATUS_OK;
    case (r.mode)
      afl_pkg::MODE_APPEND: begin
        if (frame_count >= MAX_FRAMES) begin
          o.status = afl_pkg::STATUS_FULL;
        end else begin
          frame_start[frame_count] = total_len;
          o.frame_index = INDEX_W'(frame_count);
          frame_count++;
          sum = {1'b0, total_len} + r.duration;
          if (sum[TIME_W]) begin
            total_len = afl_pkg::TOTAL_MAX;
            o.status  = afl_pkg::STATUS_OVERFLOW;
          end else begin
            total_len = sum[TIME_W-1:0];
          end
          o.total_length = total_len;
        end
      end
      afl_pkg::MODE_QUERY: begin
        if (frame_count == 0) o.status = afl_pkg::STATUS_EMPTY;
        else o.frame_index = INDEX_W'(find_frame(r.query_time));
      end
      afl_pkg::MODE_CLEAR: begin
        frame_count    = 0;
        total_len      = '0;
        o.total_length = '0;
      end
      default: ;
    endcase
    return o;
  endfunction

  task automatic plan_item(input logic [MODE_W-1:0] op,
                           input logic [TIME_W-1:0] dur,
                           input logic [TIME_W-1:0] t);
    logic [TIME_W:0] sum;
    item_backlog.insert(item_backlog.size(), '{mode: op, duration: dur, query_time: t});
    if (op != MODE_UNUSED) planned_count++;
    if (op == afl_pkg::MODE_APPEND && plan_starts.size() < MAX_FRAMES) begin
      plan_starts.insert(plan_starts.size(), plan_total);
      sum = {1'b0, plan_total} + dur;
      plan_total = sum[TIME_W] ? afl_pkg::TOTAL_MAX : sum[TIME_W-1:0];
    end else if (op == afl_pkg::MODE_CLEAR) begin
      plan_starts.delete();
      plan_total = '0;
    end
  endtask

  function automatic logic [TIME_W-1:0] pick_duration();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return '0;
    if (r < 65) return $urandom_range(1, 1000);
    if (r < 95) return $urandom_range(0, 1 << 20);
    if (r < 98) return $urandom;
    return afl_pkg::TOTAL_MAX - $urandom_range(0, 1000);
  endfunction

  function automatic logic [TIME_W-1:0] pick_query_time();
    int unsigned r;
    logic [TIME_W-1:0] t;
    r = $urandom_range(0, 99);
    if (plan_starts.size() == 0 || r < 15) begin
      t = $urandom;
    end else if (r < 55) begin
      t = $urandom_range(0, plan_total);
    end else if (r < 80) begin
      t = plan_starts[$urandom_range(0, plan_starts.size() - 1)];
    end else if (r < 90) begin
      t = plan_starts[$urandom_range(0, plan_starts.size() - 1)];
      if (t != '0) t = t - 1;
    end else begin
      t = (plan_total > afl_pkg::TOTAL_MAX - 4) ? afl_pkg::TOTAL_MAX
                                                : plan_total + $urandom_range(0, 3);
    end
    return t;
  endfunction

  // Request side: a beat stays on the bus unchanged until it is taken.
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        awaited_results.insert(awaited_results.size(), advance_timeline(offered));
        sent_count <= sent_count + 1;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (item_backlog.size() != 0 && !(pause_ok && $urandom_range(0, 99) < 33)) begin
          offered = item_backlog.pop_front();
          req_ch.valid      <= 1'b1;
          req_ch.mode       <= offered.mode;
          req_ch.duration   <= offered.duration;
          req_ch.query_time <= offered.query_time;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // One long receiver stall, so that the output register fills and the
  // block has to hold off further request beats.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && got_count >= 150) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  always @(posedge clk) begin
    frame_result_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= (hold_left == 0) && !(pause_ok && $urandom_range(0, 99) < 33);
      if (rsp_ch.valid && rsp_ch.ready) begin
        got_count <= got_count + 1;
        if (awaited_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: unexpected response beat: index %0d total %h status %0d",
                     $realtime, rsp_ch.frame_index, rsp_ch.total_length, rsp_ch.status);
        end else begin
          want = awaited_results.pop_front();
          if (rsp_ch.frame_index !== want.frame_index ||
              rsp_ch.total_length !== want.total_length ||
              rsp_ch.status !== want.status) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display({"%0t: result %0d: expected index %0d total %h status %0d, ",
                        "got index %0d total %h status %0d"},
                       $realtime, got_count, want.frame_index, want.total_length,
                       want.status, rsp_ch.frame_index, rsp_ch.total_length,
                       rsp_ch.status);
          end
        end
      end
    end
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("animation_frame_lookup test failed");
    $finish;
  end

  initial begin
    int unsigned r;
    int unsigned k;
    int unsigned queued;
    req_ch.valid      = 1'b0;
    req_ch.mode       = afl_pkg::MODE_APPEND;
    req_ch.duration   = '0;
    req_ch.query_time = '0;
    rsp_ch.ready      = 1'b0;

    // Directed part: empty table, equal start times, exact boundaries,
    // saturation of the total, clear and the unused mode.
    plan_item(afl_pkg::MODE_QUERY, '0, '0);
    plan_item(afl_pkg::MODE_QUERY, '1, '1);
    plan_item(MODE_UNUSED, '1, '1);
    plan_item(afl_pkg::MODE_APPEND, 0, 0);
    plan_item(afl_pkg::MODE_QUERY, 0, 0);
    plan_item(afl_pkg::MODE_APPEND, 0, 0);
    plan_item(afl_pkg::MODE_APPEND, 100, 0);
    plan_item(afl_pkg::MODE_APPEND, 50, 0);
    plan_item(afl_pkg::MODE_APPEND, 0, 0);
    plan_item(afl_pkg::MODE_APPEND, 25, 0);
    plan_item(afl_pkg::MODE_QUERY, 0, 0);
    plan_item(afl_pkg::MODE_QUERY, 0, 99);
    plan_item(afl_pkg::MODE_QUERY, 0, 100);
    plan_item(afl_pkg::MODE_QUERY, 0, 150);
    plan_item(afl_pkg::MODE_QUERY, 0, 149);
    plan_item(afl_pkg::MODE_QUERY, 0, '1);
    plan_item(afl_pkg::MODE_APPEND, '1, 0);
    plan_item(afl_pkg::MODE_QUERY, 0, afl_pkg::TOTAL_MAX - 1);
    plan_item(afl_pkg::MODE_APPEND, 5, 0);
    plan_item(afl_pkg::MODE_QUERY, 0, 174);
    plan_item(afl_pkg::MODE_CLEAR, '1, '1);
    plan_item(afl_pkg::MODE_QUERY, 0, 5);
    plan_item(afl_pkg::MODE_APPEND, afl_pkg::TOTAL_MAX, 0);
    plan_item(afl_pkg::MODE_APPEND, 0, 0);
    plan_item(MODE_UNUSED, '0, '0);

    // Fill the table to the brim, then knock on it a few more times.
    plan_item(afl_pkg::MODE_CLEAR, $urandom, $urandom);
    for (k = 0; k < MAX_FRAMES; k++) begin
      plan_item(afl_pkg::MODE_APPEND, $urandom_range(0, 5000), $urandom);
    end
    for (k = 0; k < 3; k++) plan_item(afl_pkg::MODE_APPEND, pick_duration(), $urandom);
    for (k = 0; k < 10; k++) plan_item(afl_pkg::MODE_QUERY, $urandom, pick_query_time());

    while (planned_count < RANDOM_ITEMS + 25) begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        if ($urandom_range(0, 1) == 0) plan_item(afl_pkg::MODE_CLEAR, $urandom, $urandom);
        repeat ($urandom_range(1, 24)) begin
          plan_item(afl_pkg::MODE_APPEND, pick_duration(), $urandom);
        end
        repeat ($urandom_range(1, 16)) begin
          plan_item(afl_pkg::MODE_QUERY, $urandom, pick_query_time());
        end
      end else begin
        repeat ($urandom_range(1, 6)) plan_item($urandom_range(0, 3), $urandom, $urandom);
      end
    end
    queued = item_backlog.size();

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (sent_count != queued) @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("animation_frame_lookup test passed");
    end else begin
      $display("animation_frame_lookup test failed");
    end
    $finish;
  end

endmodule
